// ----- src/lsa_pkg.sv -----
// Shared constants and codes for the LRU slot allocator.
package lsa_pkg;

    localparam int SLOTS   = 64;
    localparam int IDX_W   = 6;
    localparam int CNT_W   = 7;

    localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);

    localparam logic [1:0] CMD_RES_ONE  = 2'd0;
    localparam logic [1:0] CMD_RES_MANY = 2'd1;
    localparam logic [1:0] CMD_PROMOTE  = 2'd2;
    localparam logic [1:0] CMD_SET_PIN  = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_REUSED = 2'd1;
    localparam logic [1:0] ST_SHORT  = 2'd2;

endpackage

// ----- src/lsa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

// ----- src/lru_slot_allocator_with_pinning.sv -----
// LRU slot allocator with pinning: sequencer over free-stack and recency RAMs.
//
// Input channel (i_valid / o_ready) takes one command item: reserve one,
// reserve many, promote or set pin. o_ready is high only while the block is
// idle; one item is worked on at a time.
// Output channel (o_valid / i_ready) carries result items from an output
// register. A reserve many that succeeds gives count items, o_last on the
// final one; every other case gives exactly one item with o_last set.
// Each recency or free-stack entry touched takes a read phase that issues
// the RAM read and a use phase that works on the registered data. Reserve
// one with an eviction walks the order up to three times (search, close
// gap, insert). Reserve many adds one close-gap walk per eviction, then one
// shift walk and one fill pass over the count reserved slots.
// A stalled receiver holds the output register; the fill pass of reserve
// many waits on it, other commands wait in their final state.
// Reset (synchronous, active low) sets 64 active slots, all free, none
// pinned. Writing active_slots (clamped to 1..64) refills the free stack
// and empties the order, keeping pin bits; no clearing pass is needed since
// free-stack entries carry written bits.
module lru_slot_allocator_with_pinning (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [6:0]  i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [6:0]  i_count,
    input  logic [5:0]  i_slot,
    input  logic        i_pin,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_slot_index,
    output logic [1:0]  o_status,
    output logic        o_last
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EVS   = 4'd1;
    localparam logic [3:0] S_SHD   = 4'd2;
    localparam logic [3:0] S_TAKE  = 4'd3;
    localparam logic [3:0] S_MFR   = 4'd4;
    localparam logic [3:0] S_SHU   = 4'd5;
    localparam logic [3:0] S_FRONT = 4'd6;
    localparam logic [3:0] S_FILL  = 4'd7;
    localparam logic [3:0] S_PRS   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0] r_state, n_state;
    logic       r_ph, n_ph;
    logic [1:0] r_cmd, n_cmd;
    logic [6:0] r_cnt, n_cnt;
    logic [5:0] r_slot, n_slot;
    logic [6:0] r_active;
    logic [6:0] r_free, n_free;
    logic [6:0] r_occ, n_occ;
    logic [6:0] r_pos, n_pos;
    logic [6:0] r_need, n_need;
    logic [6:0] r_j, n_j;
    logic [6:0] r_k, n_k;
    logic [6:0] r_i, n_i;
    logic [5:0] r_v, n_v;
    logic       r_fill, n_fill;
    logic [5:0] r_ridx, n_ridx;
    logic [1:0] r_st, n_st;
    logic [63:0] r_pinned;
    logic [63:0] r_fsvld;
    logic [5:0] r_fsa;
    logic       r_fsvr;
    logic       r_ov, n_ov;
    logic [5:0] r_oidx, n_oidx;
    logic [1:0] r_ost, n_ost;
    logic       r_olast, n_olast;

    logic       rc_we, fs_we;
    logic [5:0] rc_wa, rc_wd, rc_ra, rc_q;
    logic [5:0] fs_wa, fs_wd, fs_ra, fs_q;
    logic [5:0] fs_val;
    logic       out_can, in_acc;
    logic [6:0] pos_m1, occ_m1, free_m1, j_m1, j_m1_k, fill_a, i_p1, base;
    logic [7:0] occ_cnt;
    logic [6:0] cfg_v;

    lsa_ram #(.WIDTH(lsa_pkg::IDX_W), .DEPTH(lsa_pkg::SLOTS)) u_order (
        .i_clk   (i_clk),
        .i_we    (rc_we),
        .i_waddr (rc_wa),
        .i_wdata (rc_wd),
        .i_raddr (rc_ra),
        .o_rdata (rc_q)
    );

    lsa_ram #(.WIDTH(lsa_pkg::IDX_W), .DEPTH(lsa_pkg::SLOTS)) u_free (
        .i_clk   (i_clk),
        .i_we    (fs_we),
        .i_waddr (fs_wa),
        .i_wdata (fs_wd),
        .i_raddr (fs_ra),
        .o_rdata (fs_q)
    );

    assign out_can = !r_ov || i_ready;
    assign o_ready = (r_state == S_IDLE);
    assign in_acc  = i_valid && o_ready;
    // free-stack entry never written since init holds its own index
    assign fs_val  = r_fsvr ? fs_q : r_fsa;

    assign pos_m1  = r_pos - 7'd1;
    assign occ_m1  = r_occ - 7'd1;
    assign free_m1 = r_free - 7'd1;
    assign j_m1    = r_j - 7'd1;
    assign j_m1_k  = j_m1 + r_k;
    assign fill_a  = r_pos + r_i;
    assign i_p1    = r_i + 7'd1;
    assign base    = r_free - r_cnt;
    assign occ_cnt = {1'b0, r_occ} + {1'b0, r_cnt};

    always_comb begin
        cfg_v = i_cfg_wr_data;
        if (i_cfg_wr_data == 7'd0) begin
            cfg_v = 7'd1;
        end else if (i_cfg_wr_data > lsa_pkg::SLOTS_C) begin
            cfg_v = lsa_pkg::SLOTS_C;
        end
    end

    always_comb begin
        n_state = r_state;
        n_ph    = r_ph;
        n_cmd   = r_cmd;
        n_cnt   = r_cnt;
        n_slot  = r_slot;
        n_free  = r_free;
        n_occ   = r_occ;
        n_pos   = r_pos;
        n_need  = r_need;
        n_j     = r_j;
        n_k     = r_k;
        n_i     = r_i;
        n_v     = r_v;
        n_fill  = r_fill;
        n_ridx  = r_ridx;
        n_st    = r_st;
        n_ov    = r_ov && !i_ready;
        n_oidx  = r_oidx;
        n_ost   = r_ost;
        n_olast = r_olast;
        rc_we   = 1'b0;
        rc_wa   = '0;
        rc_wd   = '0;
        rc_ra   = '0;
        fs_we   = 1'b0;
        fs_wa   = '0;
        fs_wd   = '0;
        fs_ra   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_cmd  = i_command;
                    n_cnt  = i_count;
                    n_slot = i_slot;
                    n_ph   = 1'b0;
                    n_pos  = r_occ;
                    n_ridx = '0;
                    n_st   = lsa_pkg::ST_OK;
                    unique case (i_command)
                        lsa_pkg::CMD_RES_ONE: begin
                            n_need  = (r_free == 7'd0) ? 7'd1 : 7'd0;
                            n_state = S_EVS;
                        end
                        lsa_pkg::CMD_RES_MANY: begin
                            if (i_count == 7'd0) begin
                                n_state = S_OUT;
                            end else begin
                                n_need  = (r_free < i_count) ? (i_count - r_free) : 7'd0;
                                n_state = S_EVS;
                            end
                        end
                        lsa_pkg::CMD_PROMOTE: begin
                            n_i     = '0;
                            n_state = S_PRS;
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_EVS: begin
                if (!r_ph) begin
                    if (r_pos == 7'd0 || r_need == 7'd0) begin
                        // eviction done: decide how to serve the reserve
                        if (r_cmd == lsa_pkg::CMD_RES_ONE) begin
                            if (r_free != 7'd0) begin
                                n_state = S_TAKE;
                            end else if (r_occ == 7'd0) begin
                                n_st    = lsa_pkg::ST_SHORT;
                                n_state = S_OUT;
                            end else begin
                                n_state = S_MFR;
                            end
                        end else if (r_free < r_cnt || occ_cnt > 8'(lsa_pkg::SLOTS)) begin
                            n_st    = lsa_pkg::ST_SHORT;
                            n_state = S_OUT;
                        end else begin
                            n_pos   = base;
                            n_free  = base;
                            n_occ   = occ_cnt[6:0];
                            n_j     = r_occ;
                            n_k     = r_cnt;
                            n_fill  = 1'b1;
                            n_state = S_SHU;
                        end
                    end else begin
                        rc_ra = pos_m1[5:0];
                        n_ph  = 1'b1;
                    end
                end else begin
                    n_ph  = 1'b0;
                    n_pos = pos_m1;
                    if (!r_pinned[rc_q]) begin
                        fs_we   = (r_free < lsa_pkg::SLOTS_C);
                        fs_wa   = r_free[5:0];
                        fs_wd   = rc_q;
                        n_free  = fs_we ? r_free + 7'd1 : r_free;
                        n_need  = r_need - 7'd1;
                        n_j     = r_pos;
                        n_state = S_SHD;
                    end
                end
            end
            S_SHD: begin
                // close the gap left by the evicted entry
                if (!r_ph) begin
                    if (r_j >= r_occ) begin
                        n_occ   = occ_m1;
                        n_state = S_EVS;
                    end else begin
                        rc_ra = r_j[5:0];
                        n_ph  = 1'b1;
                    end
                end else begin
                    rc_we = 1'b1;
                    rc_wa = j_m1[5:0];
                    rc_wd = rc_q;
                    n_j   = r_j + 7'd1;
                    n_ph  = 1'b0;
                end
            end
            S_TAKE: begin
                fs_ra = free_m1[5:0];
                if (!r_ph) begin
                    n_ph = 1'b1;
                end else begin
                    n_ph   = 1'b0;
                    n_v    = fs_val;
                    n_ridx = fs_val;
                    n_st   = lsa_pkg::ST_OK;
                    n_free = free_m1;
                    if (r_occ < lsa_pkg::SLOTS_C) begin
                        n_occ   = r_occ + 7'd1;
                        n_j     = r_occ;
                        n_k     = 7'd1;
                        n_fill  = 1'b0;
                        n_state = S_SHU;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_MFR: begin
                if (!r_ph) begin
                    rc_ra = occ_m1[5:0];
                    n_ph  = 1'b1;
                end else begin
                    n_ph    = 1'b0;
                    n_v     = rc_q;
                    n_ridx  = rc_q;
                    n_st    = lsa_pkg::ST_REUSED;
                    n_j     = occ_m1;
                    n_k     = 7'd1;
                    n_fill  = 1'b0;
                    n_state = S_SHU;
                end
            end
            S_SHU: begin
                // move entries 0..r_j-1 up by r_k, top first
                if (!r_ph) begin
                    if (r_j == 7'd0) begin
                        n_i     = '0;
                        n_state = r_fill ? S_FILL : S_FRONT;
                    end else begin
                        rc_ra = j_m1[5:0];
                        n_ph  = 1'b1;
                    end
                end else begin
                    rc_we = 1'b1;
                    rc_wa = j_m1_k[5:0];
                    rc_wd = rc_q;
                    n_j   = j_m1;
                    n_ph  = 1'b0;
                end
            end
            S_FRONT: begin
                rc_we   = 1'b1;
                rc_wa   = '0;
                rc_wd   = r_v;
                n_state = S_OUT;
            end
            S_FILL: begin
                fs_ra = fill_a[5:0];
                if (!r_ph) begin
                    n_ph = 1'b1;
                end else if (out_can) begin
                    rc_we   = 1'b1;
                    rc_wa   = r_i[5:0];
                    rc_wd   = fs_val;
                    n_ov    = 1'b1;
                    n_oidx  = fs_val;
                    n_ost   = lsa_pkg::ST_OK;
                    n_olast = (i_p1 == r_cnt);
                    n_i     = i_p1;
                    n_ph    = 1'b0;
                    if (i_p1 == r_cnt) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_PRS: begin
                if (!r_ph) begin
                    if (r_i >= r_occ) begin
                        n_state = S_OUT;
                    end else begin
                        rc_ra = r_i[5:0];
                        n_ph  = 1'b1;
                    end
                end else begin
                    n_ph = 1'b0;
                    if (rc_q == r_slot) begin
                        n_v     = r_slot;
                        n_j     = r_i;
                        n_k     = 7'd1;
                        n_fill  = 1'b0;
                        n_state = S_SHU;
                    end else begin
                        n_i = i_p1;
                    end
                end
            end
            S_OUT: begin
                if (out_can) begin
                    n_ov    = 1'b1;
                    n_oidx  = r_ridx;
                    n_ost   = r_st;
                    n_olast = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ph     <= 1'b0;
            r_active <= lsa_pkg::SLOTS_C;
            r_free   <= lsa_pkg::SLOTS_C;
            r_occ    <= '0;
            r_pinned <= '0;
            r_fsvld  <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ph    <= n_ph;
            r_ov    <= n_ov;
            if (i_cfg_wr_en) begin
                r_active <= cfg_v;
                r_free   <= cfg_v;
                r_occ    <= '0;
                r_fsvld  <= '0;
            end else begin
                r_free <= n_free;
                r_occ  <= n_occ;
                if (fs_we) begin
                    r_fsvld[fs_wa] <= 1'b1;
                end
            end
            if (in_acc && i_command == lsa_pkg::CMD_SET_PIN && {1'b0, i_slot} < r_active) begin
                r_pinned[i_slot] <= i_pin;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_cnt   <= n_cnt;
        r_slot  <= n_slot;
        r_pos   <= n_pos;
        r_need  <= n_need;
        r_j     <= n_j;
        r_k     <= n_k;
        r_i     <= n_i;
        r_v     <= n_v;
        r_fill  <= n_fill;
        r_ridx  <= n_ridx;
        r_st    <= n_st;
        r_fsa   <= fs_ra;
        r_fsvr  <= r_fsvld[fs_ra];
        r_oidx  <= n_oidx;
        r_ost   <= n_ost;
        r_olast <= n_olast;
    end

    assign o_valid      = r_ov;
    assign o_slot_index = r_oidx;
    assign o_status     = r_ost;
    assign o_last       = r_olast;

`ifndef SYNTHESIS
    a_pool_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ({1'b0, r_free} + {1'b0, r_occ} == {1'b0, r_active}))
        else $error("free plus occupied differs from active slots");

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= lsa_pkg::SLOTS_C)
        else $error("free count above slot count");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_ost == lsa_pkg::ST_SHORT) |-> (r_oidx == 6'd0 && r_olast))
        else $error("error result with slot index or not last");

    a_multi_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_olast) |-> (r_state == S_FILL))
        else $error("non-final result outside fill pass");
`endif

endmodule

// ----- dv/lru_slot_allocator_with_pinning_tb.sv -----
// Testbench for the LRU slot allocator: scoreboard against an in-bench pool predictor.
`timescale 1ns / 1ps

module lru_slot_allocator_with_pinning_tb;

    typedef struct {
        logic [1:0] command;
        logic [6:0] count;
        logic [5:0] slot;
        logic       pin;
    } t_cmd_item;

    typedef struct {
        logic [5:0] slot_index;
        logic [1:0] status;
        logic       last;
    } t_grant;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_wr_en = 1'b0;
    logic [6:0] i_cfg_wr_data = '0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [1:0] i_command = '0;
    logic [6:0] i_count = '0;
    logic [5:0] i_slot = '0;
    logic       i_pin = 1'b0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [5:0] o_slot_index;
    logic [1:0] o_status;
    logic       o_last;

    t_cmd_item pending_cmds[$];
    t_grant    expected_grants[$];
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        hold_cycles = 0;
    int        errors = 0;

    // pool mirror
    int         act_slots;
    logic [5:0] free_stk[lsa_pkg::SLOTS];
    int         free_n;
    logic [5:0] order[lsa_pkg::SLOTS];
    int         occ_n;
    bit         pinned_b[lsa_pkg::SLOTS];

    lru_slot_allocator_with_pinning u_top (.*);

    always #5 i_clk = ~i_clk;

    function automatic void pool_init();
        for (int i = 0; i < lsa_pkg::SLOTS; i++) free_stk[i] = (i < act_slots) ? 6'(i) : 6'd0;
        free_n = act_slots;
        occ_n = 0;
    endfunction

    function automatic void set_active(logic [6:0] v);
        act_slots = (v < 1) ? 1 : ((v > lsa_pkg::SLOTS) ? lsa_pkg::SLOTS : int'(v));
        pool_init();
    endfunction

    function automatic void push_grant(logic [5:0] idx, logic [1:0] st, logic lst);
        t_grant g;
        g.slot_index = idx;
        g.status = st;
        g.last = lst;
        expected_grants = {expected_grants, g};
    endfunction

    // evict up to n least recent unpinned slots onto the free stack
    function automatic void evict_lru(int n);
        int pos;
        logic [5:0] s;
        pos = occ_n;
        if (n > occ_n) n = occ_n;
        while (pos > 0 && n > 0) begin
            pos--;
            s = order[pos];
            if (!pinned_b[s]) begin
                for (int i = pos; i + 1 < occ_n; i++) order[i] = order[i + 1];
                occ_n--;
                if (free_n < lsa_pkg::SLOTS) begin
                    free_stk[free_n] = s;
                    free_n++;
                end
                n--;
            end
        end
    endfunction

    function automatic void to_front(int pos);
        logic [5:0] v;
        v = order[pos];
        for (int i = pos; i > 0; i--) order[i] = order[i - 1];
        order[0] = v;
    endfunction

    function automatic void predict_grants(t_cmd_item c);
        int cnt;
        int base;
        logic [5:0] idx;
        cnt = int'(c.count);
        case (c.command)
            lsa_pkg::CMD_RES_ONE: begin
                if (free_n == 0) evict_lru(1);
                if (free_n == 0) begin
                    if (occ_n == 0) push_grant(6'd0, lsa_pkg::ST_SHORT, 1'b1);
                    else begin
                        idx = order[occ_n - 1];
                        to_front(occ_n - 1);
                        push_grant(idx, lsa_pkg::ST_REUSED, 1'b1);
                    end
                end else begin
                    free_n--;
                    idx = free_stk[free_n];
                    if (occ_n < lsa_pkg::SLOTS) begin
                        for (int i = occ_n; i > 0; i--) order[i] = order[i - 1];
                        order[0] = idx;
                        occ_n++;
                    end
                    push_grant(idx, lsa_pkg::ST_OK, 1'b1);
                end
            end
            lsa_pkg::CMD_RES_MANY: begin
                if (cnt == 0) push_grant(6'd0, lsa_pkg::ST_OK, 1'b1);
                else begin
                    if (free_n < cnt) evict_lru(cnt - free_n);
                    if (free_n < cnt || occ_n + cnt > lsa_pkg::SLOTS)
                        push_grant(6'd0, lsa_pkg::ST_SHORT, 1'b1);
                    else begin
                        base = free_n - cnt;
                        for (int i = occ_n; i > 0; i--) order[i - 1 + cnt] = order[i - 1];
                        for (int i = 0; i < cnt; i++) begin
                            order[i] = free_stk[base + i];
                            push_grant(free_stk[base + i], lsa_pkg::ST_OK, i + 1 == cnt);
                        end
                        occ_n += cnt;
                        free_n = base;
                    end
                end
            end
            lsa_pkg::CMD_PROMOTE: begin
                for (int i = 0; i < occ_n; i++) begin
                    if (order[i] == c.slot) begin
                        to_front(i);
                        break;
                    end
                end
                push_grant(6'd0, lsa_pkg::ST_OK, 1'b1);
            end
            default: begin
                if (int'(c.slot) < act_slots) pinned_b[c.slot] = c.pin;
                push_grant(6'd0, lsa_pkg::ST_OK, 1'b1);
            end
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_cmd_item c;
        bit taken;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            taken = i_valid && o_ready;
            if (taken) begin
                c.command = i_command;
                c.count = i_count;
                c.slot = i_slot;
                c.pin = i_pin;
                predict_grants(c);
            end
            if (!i_valid || taken) begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    c = pending_cmds.pop_front();
                    i_command <= c.command;
                    i_count <= c.count;
                    i_slot <= c.slot;
                    i_pin <= c.pin;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall and long hold-off
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_grant g;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_grants.size() == 0) begin
                $error("unexpected result item: slot_index %0d status %0d last %0d",
                       o_slot_index, o_status, o_last);
                errors++;
            end else begin
                g = expected_grants.pop_front();
                if (o_slot_index !== g.slot_index) begin
                    $error("slot_index: expected %0d, got %0d", g.slot_index, o_slot_index);
                    errors++;
                end
                if (o_status !== g.status) begin
                    $error("status: expected %0d, got %0d", g.status, o_status);
                    errors++;
                end
                if (o_last !== g.last) begin
                    $error("last: expected %0d, got %0d", g.last, o_last);
                    errors++;
                end
            end
        end
    end

    task automatic add_cmd(logic [1:0] cmd, logic [6:0] cnt, logic [5:0] s, logic p);
        t_cmd_item c;
        c.command = cmd;
        c.count = cnt;
        c.slot = s;
        c.pin = p;
        pending_cmds = {pending_cmds, c};
    endtask

    task automatic drain();
        while (pending_cmds.size() != 0 || i_valid || expected_grants.size() != 0)
            @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    task automatic write_active(logic [6:0] v);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        set_active(v);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic add_random(int n, int lim);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 35) add_cmd(lsa_pkg::CMD_RES_ONE, 7'($urandom), 6'($urandom),
                                1'($urandom));
            else if (r < 55) begin
                if ($urandom_range(15) == 0)
                    add_cmd(lsa_pkg::CMD_RES_MANY, 7'($urandom), 6'($urandom),
                            1'($urandom));
                else
                    add_cmd(lsa_pkg::CMD_RES_MANY, 7'($urandom_range(lim)), 6'($urandom),
                            1'($urandom));
            end else if (r < 75) add_cmd(lsa_pkg::CMD_PROMOTE, 7'($urandom), 6'($urandom),
                                         1'($urandom));
            else add_cmd(lsa_pkg::CMD_SET_PIN, 7'($urandom), 6'($urandom_range(lim + 1)),
                         $urandom_range(9) < 4);
        end
    endtask

    initial begin
        act_slots = lsa_pkg::SLOTS;
        for (int i = 0; i < lsa_pkg::SLOTS; i++) pinned_b[i] = 1'b0;
        pool_init();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: small pool, exhaustion, pins, short reservations
        write_active(7'd4);
        add_cmd(lsa_pkg::CMD_RES_MANY, 7'd0, 6'd0, 1'b0);
        for (int i = 0; i < 5; i++) add_cmd(lsa_pkg::CMD_RES_ONE, 7'd0, 6'd0, 1'b0);
        add_cmd(lsa_pkg::CMD_PROMOTE, 7'd0, 6'd2, 1'b0);
        add_cmd(lsa_pkg::CMD_PROMOTE, 7'd0, 6'd63, 1'b0);
        for (int i = 0; i < 4; i++) add_cmd(lsa_pkg::CMD_SET_PIN, 7'd0, 6'(i), 1'b1);
        add_cmd(lsa_pkg::CMD_SET_PIN, 7'd0, 6'd63, 1'b1);   // out of range, ignored
        add_cmd(lsa_pkg::CMD_RES_ONE, 7'd0, 6'd0, 1'b0);    // all pinned: forced reuse
        add_cmd(lsa_pkg::CMD_RES_MANY, 7'd2, 6'd0, 1'b0);   // short
        add_cmd(lsa_pkg::CMD_RES_MANY, 7'd127, 6'd0, 1'b0);
        add_cmd(lsa_pkg::CMD_SET_PIN, 7'd0, 6'd1, 1'b0);
        add_cmd(lsa_pkg::CMD_SET_PIN, 7'd0, 6'd3, 1'b0);
        add_cmd(lsa_pkg::CMD_RES_MANY, 7'd2, 6'd0, 1'b0);   // evicts two
        add_cmd(lsa_pkg::CMD_RES_MANY, 7'd4, 6'd0, 1'b0);   // partial evict, then short
        add_cmd(lsa_pkg::CMD_SET_PIN, 7'd0, 6'd0, 1'b0);
        add_cmd(lsa_pkg::CMD_SET_PIN, 7'd0, 6'd2, 1'b0);
        drain();

        write_active(7'd127);                            // clamps to full pool
        add_cmd(lsa_pkg::CMD_RES_MANY, 7'd64, 6'd0, 1'b0);
        add_cmd(lsa_pkg::CMD_RES_MANY, 7'd64, 6'd0, 1'b0);
        add_cmd(lsa_pkg::CMD_RES_ONE, 7'd0, 6'd0, 1'b0);
        add_cmd(lsa_pkg::CMD_PROMOTE, 7'd0, 6'd0, 1'b0);
        drain();

        write_active(7'd0);                              // clamps to one slot
        add_random(30, 2);
        drain();

        write_active(7'd8);
        send_idle_pct = 61;
        add_random(100, 8);
        drain();

        write_active(7'd64);
        send_idle_pct = 0;
        recv_idle_pct = 61;
        add_random(100, 10);
        hold_cycles = 4000;                              // block backs up behind the output
        drain();

        write_active(7'd2);
        send_idle_pct = 33;
        recv_idle_pct = 33;
        add_random(60, 3);
        drain();

        write_active(7'd40);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random(140, 12);
        drain();

        if (errors == 0) $display("lru_slot_allocator_with_pinning: match");
        else $display("lru_slot_allocator_with_pinning: mismatch");
        $finish;
    end

    initial begin
        #200ms;
        $display("lru_slot_allocator_with_pinning: mismatch");
        $finish;
    end

endmodule

// ----- lru_slot_allocator_with_pinning.f -----
src/lsa_pkg.sv
src/lsa_ram.sv
src/lru_slot_allocator_with_pinning.sv
dv/lru_slot_allocator_with_pinning_tb.sv
